// ===== rtl/core/dtcr_pkg.sv =====
`default_nettype none

package dtcr_pkg;

   // fixed-point and frame constants
   localparam int FRAC_BITS     = 16;
   localparam int MAX_DIM       = 4096;
   localparam int DIM_W         = 13;
   localparam int DEPTH_LOW_MM  = 500;
   localparam int DEPTH_HIGH_MM = 8000;

   // divider: one quotient bit per cell
   localparam int DIV_BITS = 32;
   localparam int DVSR_W   = 13;

   // target sum: 32-bit product + 32-bit offset - 32-bit quotient
   localparam int SUM_W = 36;
   localparam int PIX_W = SUM_W - FRAC_BITS;

   typedef enum logic [2:0] {
      CSR_X_GAIN        = 3'd0,
      CSR_X_OFFSET      = 3'd1,
      CSR_BASELINE_TERM = 3'd2,
      CSR_Y_GAIN        = 3'd3,
      CSR_Y_OFFSET      = 3'd4,
      CSR_OUT_WIDTH     = 3'd5,
      CSR_OUT_HEIGHT    = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic [15:0] depth_mm;
      logic [11:0] src_col;
      logic [11:0] src_row;
   } req_type;

   typedef struct packed {
      logic [11:0] dst_col;
      logic [11:0] dst_row;
      logic [12:0] dst_depth_mm;
   } rsp_type;

   typedef struct packed {
      logic [19:0]        x_gain;
      logic signed [31:0] x_offset;
      logic signed [31:0] baseline_term;
      logic [19:0]        y_gain;
      logic signed [31:0] y_offset;
      logic [DIM_W-1:0]   out_width;
      logic [DIM_W-1:0]   out_height;
   } cfg_type;

   // item traveling down the divider chain
   typedef struct packed {
      logic                keep;     // depth inside the accepted range
      logic [DVSR_W-1:0]   depth;    // divisor and payload depth
      logic [DVSR_W-1:0]   rem;      // partial remainder
      logic [DIV_BITS-1:0] num;      // dividend shifting out, quotient shifting in
      logic [31:0]         xprod;    // x_gain * src_col
      logic [31:0]         yprod;    // y_gain * src_row
   } div_item_type;

endpackage

`default_nettype wire

// ===== rtl/core/dtcr_div_cell.sv =====
`default_nettype none

// One restoring-division step; retires one quotient bit per item.
module dtcr_div_cell import dtcr_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         in_valid,
   output logic              in_ready,
   input  wire div_item_type in_item,
   output logic              out_valid,
   input  wire logic         out_ready,
   output div_item_type      out_item
);

   logic               valid_ff;
   div_item_type       item_ff;
   div_item_type       item_in;
   logic [DVSR_W:0]    trial;
   logic               fits;

   always_comb begin
      trial   = {in_item.rem, in_item.num[DIV_BITS-1]};
      fits    = trial >= {1'b0, in_item.depth};
      item_in = in_item;
      item_in.rem = fits ? DVSR_W'(trial - {1'b0, in_item.depth}) : trial[DVSR_W-1:0];
      item_in.num = {in_item.num[DIV_BITS-2:0], fits};
   end

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_item  = item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         item_ff <= item_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/dtcr_finish.sv =====
`default_nettype none

// Sums the Q16 target, truncates toward zero, clips to the frame, holds the result.
module dtcr_finish import dtcr_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire cfg_type      cfg,
   input  wire logic         in_valid,
   output logic              in_ready,
   input  wire div_item_type in_item,
   output logic              rsp_valid,
   input  wire logic         rsp_ready,
   output rsp_type           rsp_data
);

   logic                    out_valid_ff;
   rsp_type                 rsp_ff;
   rsp_type                 rsp_in;
   logic signed [SUM_W-1:0] quo_s;
   logic signed [SUM_W-1:0] x_sum;
   logic signed [SUM_W-1:0] y_sum;
   logic [PIX_W-1:0]        px;
   logic [PIX_W-1:0]        py;
   logic                    x_ok;
   logic                    y_ok;
   logic [DIM_W-1:0]        width_lim;
   logic [DIM_W-1:0]        height_lim;
   logic                    hit;

   // truncation toward zero; values in (-1, 0) land on pixel 0, other negatives miss
   function automatic logic [PIX_W:0] to_pixel(input logic signed [SUM_W-1:0] v);
      logic [PIX_W:0] r;
      r = '0;
      if (!v[SUM_W-1]) begin
         r = {1'b1, v[SUM_W-1:FRAC_BITS]};
      end else if ((&v[SUM_W-1:FRAC_BITS]) && (v[FRAC_BITS-1:0] != '0)) begin
         r = {1'b1, {PIX_W{1'b0}}};
      end
      return r;
   endfunction

   always_comb begin
      quo_s = cfg.baseline_term[31] ? -$signed({4'b0, in_item.num})
                                    :  $signed({4'b0, in_item.num});
      x_sum = $signed({4'b0, in_item.xprod}) + SUM_W'(cfg.x_offset) - quo_s;
      y_sum = $signed({4'b0, in_item.yprod}) + SUM_W'(cfg.y_offset);
      {x_ok, px} = to_pixel(x_sum);
      {y_ok, py} = to_pixel(y_sum);
      width_lim  = (cfg.out_width  > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : cfg.out_width;
      height_lim = (cfg.out_height > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : cfg.out_height;
      hit = in_item.keep && x_ok && y_ok
            && (px < PIX_W'(width_lim)) && (py < PIX_W'(height_lim));
      rsp_in.dst_col      = px[11:0];
      rsp_in.dst_row      = py[11:0];
      rsp_in.dst_depth_mm = in_item.depth;
   end

   assign in_ready  = !out_valid_ff || rsp_ready;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (in_ready) begin
         out_valid_ff <= in_valid && hit;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid && hit) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/depth_to_color_registration.sv =====
// Stages from req transfer to rsp_valid: 1 product stage, 32 divider cells, 1 output stage.
// Throughput: one pixel per cycle unless the output stalls; the 32-cell divider chain retires
// one quotient bit of |baseline_term|/depth per cell and hands the item on every unstalled cycle.
// Empty stages collapse while the output stalls, so inputs keep flowing into bubbles.
// Reset (synchronous): all stages empty, registers back to their defaults
// (gains 1.0, offsets 0, frame 640 x 480).
`default_nettype none

module depth_to_color_registration import dtcr_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   // configuration writes
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [2:0]  csr_index,
   input  wire logic [31:0] csr_wdata,
   // depth pixels in
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire req_type     req_data,
   // registered pixel writes out
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output rsp_type          rsp_data
);

   // ---------------------------------------------------------------
   // Configuration registers; writes are expected only while the pipe is idle
   // ---------------------------------------------------------------
   cfg_type cfg_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.x_gain        <= 20'd65536;
         cfg_ff.x_offset      <= '0;
         cfg_ff.baseline_term <= '0;
         cfg_ff.y_gain        <= 20'd65536;
         cfg_ff.y_offset      <= '0;
         cfg_ff.out_width     <= DIM_W'(640);
         cfg_ff.out_height    <= DIM_W'(480);
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_X_GAIN:        cfg_ff.x_gain        <= csr_wdata[19:0];
            CSR_X_OFFSET:      cfg_ff.x_offset      <= csr_wdata;
            CSR_BASELINE_TERM: cfg_ff.baseline_term <= csr_wdata;
            CSR_Y_GAIN:        cfg_ff.y_gain        <= csr_wdata[19:0];
            CSR_Y_OFFSET:      cfg_ff.y_offset      <= csr_wdata;
            CSR_OUT_WIDTH:     cfg_ff.out_width     <= csr_wdata[DIM_W-1:0];
            CSR_OUT_HEIGHT:    cfg_ff.out_height    <= csr_wdata[DIM_W-1:0];
            default: ;  // unmapped index: dropped
         endcase
      end
   end

   // ---------------------------------------------------------------
   // Stage handshake arrays: stage 0 is the product register, stage k
   // is the output of divider cell k-1.
   // ---------------------------------------------------------------
   logic         stg_valid [DIV_BITS+1];
   logic         stg_ready [DIV_BITS+1];
   div_item_type stg_item  [DIV_BITS+1];

   // ---------------------------------------------------------------
   // Product stage: range check, gain products, |baseline_term|
   // ---------------------------------------------------------------
   logic         front_valid_ff;
   div_item_type front_ff;
   div_item_type front_in;

   always_comb begin
      front_in.keep  = (req_data.depth_mm > 16'(DEPTH_LOW_MM))
                       && (req_data.depth_mm < 16'(DEPTH_HIGH_MM));
      front_in.depth = req_data.depth_mm[DVSR_W-1:0];
      front_in.rem   = '0;
      // magnitude; the most negative value maps to 2^31 unsigned
      front_in.num   = cfg_ff.baseline_term[31] ? DIV_BITS'(-cfg_ff.baseline_term)
                                                : DIV_BITS'(cfg_ff.baseline_term);
      front_in.xprod = 32'(cfg_ff.x_gain * req_data.src_col);
      front_in.yprod = 32'(cfg_ff.y_gain * req_data.src_row);
   end

   assign req_ready    = !front_valid_ff || stg_ready[0];
   assign stg_valid[0] = front_valid_ff;
   assign stg_item[0]  = front_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         front_valid_ff <= 1'b0;
      end else if (req_ready) begin
         front_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         front_ff <= front_in;
      end
   end

   // ---------------------------------------------------------------
   // Divider chain: one cell per quotient bit, MSB first
   // ---------------------------------------------------------------
   for (genvar k = 0; k < DIV_BITS; k++) begin : g_cell
      dtcr_div_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (stg_valid[k]),
         .in_ready  (stg_ready[k]),
         .in_item   (stg_item[k]),
         .out_valid (stg_valid[k+1]),
         .out_ready (stg_ready[k+1]),
         .out_item  (stg_item[k+1])
      );
   end

   // ---------------------------------------------------------------
   // Target sum, truncation, frame clip and output register
   // ---------------------------------------------------------------
   dtcr_finish u_finish (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (stg_valid[DIV_BITS]),
      .in_ready  (stg_ready[DIV_BITS]),
      .in_item   (stg_item[DIV_BITS]),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

`ifndef SYNTHESIS
   logic [DIM_W-1:0] chk_width;
   logic [DIM_W-1:0] chk_height;

   assign chk_width  = (cfg_ff.out_width  > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM)
                                                             : cfg_ff.out_width;
   assign chk_height = (cfg_ff.out_height > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM)
                                                             : cfg_ff.out_height;

   a_depth_in_range : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.dst_depth_mm > 13'(DEPTH_LOW_MM))
                    && (rsp_data.dst_depth_mm < 13'(DEPTH_HIGH_MM)))
      else $error("result depth outside accepted range");

   a_col_in_frame : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ({1'b0, rsp_data.dst_col} < chk_width))
      else $error("result column outside frame");

   a_row_in_frame : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ({1'b0, rsp_data.dst_row} < chk_height))
      else $error("result row outside frame");

   a_empty_after_reset : assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid && !front_valid_ff)
      else $error("pipeline not empty after reset");
`endif

endmodule

`default_nettype wire

// ===== tb/dtcr_write_checker.sv =====
`timescale 1ns / 100ps

// Watches the csr, req and rsp channels, projects each depth pixel into the
// color frame and compares every pixel write against the oldest projection.
module dtcr_write_checker import dtcr_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_valid,
   input  wire logic        csr_ready,
   input  wire logic [2:0]  csr_index,
   input  wire logic [31:0] csr_wdata,
   input  wire logic        req_valid,
   input  wire logic        req_ready,
   input  wire req_type     req_data,
   input  wire logic        rsp_valid,
   input  wire logic        rsp_ready,
   input  wire rsp_type     rsp_data,
   output int unsigned      fail_count,
   output int unsigned      pending
);

   cfg_type     shadow_cfg;
   rsp_type     expected_writes[$];
   int unsigned mismatches;

   function automatic cfg_type cfg_after_reset();
      cfg_type c;
      c.x_gain        = 20'd65536;
      c.x_offset      = '0;
      c.baseline_term = '0;
      c.y_gain        = 20'd65536;
      c.y_offset      = '0;
      c.out_width     = 13'd640;
      c.out_height    = 13'd480;
      return c;
   endfunction

   // Q16 truncation toward zero
   function automatic longint to_pixel(input longint q);
      if (q < 0) begin
         return -((-q) >>> FRAC_BITS);
      end
      return q >>> FRAC_BITS;
   endfunction

   // Returns 1 and the expected write when the pixel lands inside the frame.
   function automatic bit project_pixel(input cfg_type c, input req_type px,
                                        output rsp_type wr);
      longint depth, col, row, xq, yq, tx, ty, w, h;
      longint gx, gy, ox, oy, bt;
      depth = longint'(px.depth_mm);
      col   = longint'(px.src_col);
      row   = longint'(px.src_row);
      gx    = longint'(c.x_gain);
      gy    = longint'(c.y_gain);
      ox    = longint'($signed(c.x_offset));
      oy    = longint'($signed(c.y_offset));
      bt    = longint'($signed(c.baseline_term));
      w     = (c.out_width > MAX_DIM) ? longint'(MAX_DIM) : longint'(c.out_width);
      h     = (c.out_height > MAX_DIM) ? longint'(MAX_DIM) : longint'(c.out_height);
      wr    = '0;
      if (depth <= DEPTH_LOW_MM || depth >= DEPTH_HIGH_MM) begin
         return 1'b0;
      end
      xq = gx * col + ox - bt / depth;
      yq = gy * row + oy;
      tx = to_pixel(xq);
      ty = to_pixel(yq);
      if (tx < 0 || ty < 0 || tx >= w || ty >= h) begin
         return 1'b0;
      end
      wr.dst_col      = tx[11:0];
      wr.dst_row      = ty[11:0];
      wr.dst_depth_mm = depth[12:0];
      return 1'b1;
   endfunction

   always @(posedge clock) begin
      rsp_type wr, want;
      if (reset) begin
         shadow_cfg = cfg_after_reset();
         expected_writes.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_X_GAIN:        shadow_cfg.x_gain        = csr_wdata[19:0];
               CSR_X_OFFSET:      shadow_cfg.x_offset      = csr_wdata;
               CSR_BASELINE_TERM: shadow_cfg.baseline_term = csr_wdata;
               CSR_Y_GAIN:        shadow_cfg.y_gain        = csr_wdata[19:0];
               CSR_Y_OFFSET:      shadow_cfg.y_offset      = csr_wdata;
               CSR_OUT_WIDTH:     shadow_cfg.out_width     = csr_wdata[DIM_W-1:0];
               CSR_OUT_HEIGHT:    shadow_cfg.out_height    = csr_wdata[DIM_W-1:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            if (project_pixel(shadow_cfg, req_data, wr)) begin
               expected_writes.push_back(wr);
            end
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_writes.size() == 0) begin
               $error("unexpected pixel write col %0d row %0d depth %0d",
                      rsp_data.dst_col, rsp_data.dst_row, rsp_data.dst_depth_mm);
               mismatches++;
            end else begin
               want = expected_writes.pop_front();
               if (rsp_data.dst_col !== want.dst_col) begin
                  $error("dst_col: expected %0d, actual %0d", want.dst_col, rsp_data.dst_col);
                  mismatches++;
               end
               if (rsp_data.dst_row !== want.dst_row) begin
                  $error("dst_row: expected %0d, actual %0d", want.dst_row, rsp_data.dst_row);
                  mismatches++;
               end
               if (rsp_data.dst_depth_mm !== want.dst_depth_mm) begin
                  $error("dst_depth_mm: expected %0d, actual %0d",
                         want.dst_depth_mm, rsp_data.dst_depth_mm);
                  mismatches++;
               end
            end
         end
      end
      fail_count <= mismatches;
      pending    <= expected_writes.size();
   end

endmodule

// ===== tb/tb_depth_to_color_registration.sv =====
`timescale 1ns / 100ps

module tb_depth_to_color_registration;
   import dtcr_pkg::*;

   // index past the end of the register list; the block must ignore it
   localparam logic [2:0] CSR_SPARE_INDEX = 3'd7;

   localparam int RESET_CYCLES    = 11;
   localparam int PHASES          = 8;
   localparam int ITEMS_PER_PHASE = 245;
   // pipeline is 34 deep; idle margin before reconfiguring and at the end
   localparam int SETTLE_CYCLES   = 40;
   localparam int DRAIN_CYCLES    = 100;
   // receiver hold-off long enough to back the pipeline up into req_ready
   localparam int HOLD_OFF_CYCLES = 400;
   // cycles without any transfer before the run is declared hung
   localparam int WATCHDOG_LIMIT  = 4000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_index = CSR_X_GAIN;
   logic [31:0] csr_wdata = '0;
   logic        req_valid = 1'b0;
   logic        req_ready;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   rsp_type     rsp_data;

   int unsigned fail_count;
   int unsigned pending;

   // stimulus -> receiver: ask for the one long hold-off
   logic        hold_off_go = 1'b0;
   cfg_type     cur_cfg;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   depth_to_color_registration u_top (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   dtcr_write_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data),
      .fail_count (fail_count),
      .pending    (pending)
   );

   // Offer one depth pixel and hold it until the transfer. Valid stays high on
   // return so a following call keeps the stream back to back.
   task automatic push_pixel(input logic [15:0] depth, input logic [11:0] col,
                             input logic [11:0] row);
      req_type px;
      px.depth_mm = depth;
      px.src_col  = col;
      px.src_row  = row;
      req_valid <= 1'b1;
      req_data  <= px;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic csr_put(input logic [2:0] idx, input logic [31:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
   endtask

   // Reconfigure only with the pipeline empty: every expected write seen,
   // then enough cycles for pixels that produce no write to fall out too.
   // The first edge lets the pending count take in the last transfer.
   // With junk set the unused upper data bits carry random values and the
   // spare index gets a write as well.
   task automatic apply_config(input cfg_type c, input bit junk);
      logic [31:0] noise;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      noise = junk ? $urandom : 32'd0;
      csr_put(CSR_X_GAIN,        {noise[31:20], c.x_gain});
      csr_put(CSR_X_OFFSET,      c.x_offset);
      csr_put(CSR_BASELINE_TERM, c.baseline_term);
      noise = junk ? $urandom : 32'd0;
      csr_put(CSR_Y_GAIN,        {noise[31:20], c.y_gain});
      csr_put(CSR_Y_OFFSET,      c.y_offset);
      noise = junk ? $urandom : 32'd0;
      csr_put(CSR_OUT_WIDTH,     {noise[31:DIM_W], c.out_width});
      noise = junk ? $urandom : 32'd0;
      csr_put(CSR_OUT_HEIGHT,    {noise[31:DIM_W], c.out_height});
      if (junk) begin
         csr_put(CSR_SPARE_INDEX, $urandom);
      end
      csr_valid <= 1'b0;
   endtask

   // Per-phase register set. Default is a plausible calibration (gain near
   // 1.0, offsets within a few hundred pixels); some phases pin extremes.
   function automatic cfg_type pick_config(input int unsigned phase);
      cfg_type c;
      c.x_gain        = 20'($urandom_range(49152, 98304));
      c.y_gain        = 20'($urandom_range(49152, 98304));
      c.x_offset      = int'($urandom_range(0, 26214400)) - 13107200;
      c.y_offset      = int'($urandom_range(0, 26214400)) - 13107200;
      c.baseline_term = $urandom;
      c.out_width     = DIM_W'($urandom_range(1, MAX_DIM));
      c.out_height    = DIM_W'($urandom_range(1, MAX_DIM));
      case (phase)
         1: begin
            // largest gains against the most negative offsets, full frame
            c.x_gain        = 20'hFFFFF;
            c.y_gain        = 20'hFFFFF;
            c.x_offset      = 32'sh8000_0000;
            c.y_offset      = 32'sh8000_0000;
            c.baseline_term = 32'sh7FFF_FFFF;
            c.out_width     = DIM_W'(MAX_DIM);
            c.out_height    = DIM_W'(MAX_DIM);
         end
         2: begin
            // zero gains, 1 x 1 frame: every kept pixel lands on (0,0)
            c.x_gain        = '0;
            c.y_gain        = '0;
            c.x_offset      = $urandom_range(0, 65535);
            c.y_offset      = $urandom_range(0, 65535);
            c.baseline_term = '0;
            c.out_width     = 13'd1;
            c.out_height    = 13'd1;
         end
         3: begin
            // zero-width frame and the most positive offsets: nothing kept
            c.x_gain        = '0;
            c.y_gain        = '0;
            c.x_offset      = 32'sh7FFF_FFFF;
            c.y_offset      = 32'sh7FFF_FFFF;
            c.baseline_term = 32'sh8000_0000;
            c.out_width     = '0;
         end
         4: begin
            // frame sizes above the maximum are clamped
            c.out_width     = 13'h1FFF;
            c.out_height    = DIM_W'($urandom_range(MAX_DIM + 1, 8191));
         end
         6: begin
            c.out_width     = 13'd640;
            c.out_height    = 13'd480;
         end
         default: ;
      endcase
      return c;
   endfunction

   // Receiver: a pattern of segments (always ready, mostly ready, coin flip,
   // mostly stalled), plus one long hold-off on request from the stimulus.
   initial begin
      int unsigned seg_left, seg_kind, hold_left;
      bit          hold_done;
      seg_left  = 0;
      seg_kind  = 0;
      hold_left = 0;
      hold_done = 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (hold_off_go && !hold_done) begin
            hold_done = 1'b1;
            hold_left = HOLD_OFF_CYCLES;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            if (seg_left == 0) begin
               seg_kind = $urandom_range(0, 3);
               seg_left = $urandom_range(5, 80);
            end
            seg_left--;
            case (seg_kind)
               0:       rsp_ready <= 1'b1;
               1:       rsp_ready <= ($urandom_range(0, 3) != 0);
               2:       rsp_ready <= 1'($urandom_range(0, 1));
               default: rsp_ready <= ($urandom_range(0, 3) == 0);
            endcase
         end
         @(posedge clock);
      end
   end

   // Watchdog: any cycle with a transfer on some channel resets the count.
   initial begin
      int unsigned idle_cycles;
      idle_cycles = 0;
      forever begin
         @(posedge clock);
         if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
             (csr_valid && csr_ready)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("== FAIL ==");
            $finish;
         end
      end
   end

   // Stimulus and verdict.
   initial begin
      cfg_type     c;
      int unsigned phase, sent, burst, gap, k, col_span, row_span;
      logic [15:0] depth;
      logic [11:0] col, row;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // --- directed, reset registers (gain 1.0, offsets 0, 640 x 480) ---
      push_pixel(16'd0,     12'd10,   12'd10);    // no reading
      push_pixel(16'd500,   12'd10,   12'd10);    // lower depth bound, dropped
      push_pixel(16'd501,   12'd0,    12'd0);     // first kept depth, corner
      push_pixel(16'd7999,  12'd639,  12'd479);   // last kept depth, far corner
      push_pixel(16'd8000,  12'd20,   12'd20);    // upper depth bound, dropped
      push_pixel(16'hFFFF,  12'hFFF,  12'hFFF);   // all ones
      push_pixel(16'd1000,  12'd640,  12'd0);     // one column past the frame
      push_pixel(16'd1000,  12'd0,    12'd480);   // one row past the frame
      push_pixel(16'd7000,  12'hFFF,  12'hFFF);   // far outside
      req_valid <= 1'b0;

      // --- directed: half-pixel negative x offset truncates to column 0,
      //     a full negative pixel on y drops row 0 but keeps row 1 ---
      c.x_gain        = 20'd65536;
      c.y_gain        = 20'd65536;
      c.x_offset      = -32768;
      c.y_offset      = -65536;
      c.baseline_term = '0;
      c.out_width     = DIM_W'(MAX_DIM);
      c.out_height    = DIM_W'(MAX_DIM);
      apply_config(c, 1'b0);
      push_pixel(16'd2000,  12'd0,    12'd1);
      push_pixel(16'd2000,  12'd0,    12'd0);
      push_pixel(16'd3000,  12'hFFF,  12'hFFF);
      push_pixel(16'd501,   12'd1,    12'd4095);
      req_valid <= 1'b0;

      // --- directed: most negative baseline term pushes columns right ---
      c.x_offset      = '0;
      c.y_offset      = '0;
      c.baseline_term = 32'sh8000_0000;
      c.out_width     = 13'd640;
      c.out_height    = 13'd480;
      apply_config(c, 1'b0);
      push_pixel(16'd501,   12'd0,    12'd0);
      push_pixel(16'd7999,  12'd0,    12'd479);
      push_pixel(16'd501,   12'd575,  12'd100);   // shifted past the edge
      push_pixel(16'd4000,  12'd600,  12'd200);
      req_valid <= 1'b0;

      // --- random phases ---
      for (phase = 0; phase < PHASES; phase++) begin
         cur_cfg = pick_config(phase);
         apply_config(cur_cfg, phase[0]);
         if (phase == 0) begin
            hold_off_go <= 1'b1;
         end
         // aim in-range pixels at the frame that is actually configured
         col_span = (cur_cfg.out_width == 0) ? 1 :
                    (cur_cfg.out_width > MAX_DIM) ? MAX_DIM : cur_cfg.out_width;
         row_span = (cur_cfg.out_height == 0) ? 1 :
                    (cur_cfg.out_height > MAX_DIM) ? MAX_DIM : cur_cfg.out_height;
         sent = 0;
         while (sent < ITEMS_PER_PHASE) begin
            burst = $urandom_range(1, 40);
            for (k = 0; k < burst && sent < ITEMS_PER_PHASE; k++) begin
               if ($urandom_range(0, 3) == 0) begin
                  // noise: any value of every field
                  depth = 16'($urandom);
                  col   = 12'($urandom);
                  row   = 12'($urandom);
               end else begin
                  case ($urandom_range(0, 9))
                     0:       depth = 16'(DEPTH_LOW_MM + $urandom_range(0, 1));
                     1:       depth = 16'(DEPTH_HIGH_MM - $urandom_range(0, 1));
                     default: depth = 16'($urandom_range(DEPTH_LOW_MM + 1,
                                                         DEPTH_HIGH_MM - 1));
                  endcase
                  col = 12'($urandom_range(0, col_span - 1));
                  row = 12'($urandom_range(0, row_span - 1));
               end
               push_pixel(depth, col, row);
               sent++;
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0) begin
               req_valid <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
         req_valid <= 1'b0;
      end

      // drain: all expected writes seen, then let stragglers show up
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
